// File: rtl/core/ned_ecef_velocity_position_estimator_macros.svh
// ----------------------------------------------------------------------------
// NED/ECEF estimator assertion macros
// Shorthand for clocked assertions with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef NED_ECEF_VELOCITY_POSITION_ESTIMATOR_MACROS_SVH
`define NED_ECEF_VELOCITY_POSITION_ESTIMATOR_MACROS_SVH

// Same-cycle implication.
`define NEVPE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NEVPE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/nevpe_pkg.sv
// ----------------------------------------------------------------------------
// NED/ECEF estimator package
// Widths, codes, payload structs and operand helpers shared by the block.
// ----------------------------------------------------------------------------
package nevpe_pkg;

  localparam int VEL_W       = 32;
  localparam int POS_W       = 48;
  localparam int AXES        = 3;
  localparam int AXIS_W      = 2;
  // Operand A of the shared unit holds positions plus a little headroom.
  localparam int OPA_W       = POS_W + 2;
  localparam int OPB_W       = 34;
  localparam int LO_CHUNK    = 33;
  localparam int PROD_W      = 2 * OPB_W;
  localparam int ACC_W       = POS_W + 40;
  localparam int T_W         = 36;
  localparam int SHIFT_TRAPZ = 25;
  localparam int SHIFT_TRIG  = 30;
  localparam int SUB_W       = 3;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);
  localparam logic [SUB_W-1:0]  SUB_WB    = 3'd6;

  localparam logic [30:0] BLEND_ONE  = 31'h4000_0000;
  localparam logic [31:0] TRIG_ONE   = 32'h4000_0000;
  localparam logic [31:0] STEP_RESET = 32'd167772;

  typedef enum logic [2:0] {
    CFG_STEP_PERIOD = 3'd0,
    CFG_VEL_BLEND   = 3'd1,
    CFG_POS_BLEND   = 3'd2,
    CFG_COS_LAT     = 3'd3,
    CFG_SIN_LAT     = 3'd4,
    CFG_COS_LON     = 3'd5,
    CFG_SIN_LON     = 3'd6
  } nevpe_cfg_e;

  // One job is one accumulated sum of up to two products.
  typedef enum logic [2:0] {
    JOB_VT, // velocity trapezoid step
    JOB_VB, // velocity blend
    JOB_ET, // horizontal ECEF term
    JOB_EX,
    JOB_EY,
    JOB_EZ,
    JOB_PT, // position trapezoid step
    JOB_PB  // position blend
  } nevpe_job_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } nevpe_state_e;

  typedef struct packed {
    nevpe_job_e        job;
    logic [AXIS_W-1:0] axis;
    logic              preload;
    logic              issue;
    logic              hi;
    logic              term;
    logic              wb;
  } nevpe_ctrl_t;

  typedef struct packed {
    logic vel_ok;
    logic pos_ok;
  } nevpe_status_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] accel_north;
    logic signed [VEL_W-1:0] accel_east;
    logic signed [VEL_W-1:0] accel_down;
    logic signed [VEL_W-1:0] vel_meas_north;
    logic signed [VEL_W-1:0] vel_meas_east;
    logic signed [VEL_W-1:0] vel_meas_down;
    logic signed [POS_W-1:0] pos_meas_x;
    logic signed [POS_W-1:0] pos_meas_y;
    logic signed [POS_W-1:0] pos_meas_z;
  } nevpe_in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_est_north;
    logic signed [VEL_W-1:0] vel_est_east;
    logic signed [VEL_W-1:0] vel_est_down;
    logic signed [POS_W-1:0] pos_est_x;
    logic signed [POS_W-1:0] pos_est_y;
    logic signed [POS_W-1:0] pos_est_z;
  } nevpe_out_t;

  // Sign extension of a velocity into operand A.
  function automatic logic signed [OPA_W-1:0] ext_vel(input logic signed [VEL_W-1:0] v);
    return {{(OPA_W-VEL_W){v[VEL_W-1]}}, v};
  endfunction

  function automatic logic signed [OPA_W-1:0] ext_pos(input logic signed [POS_W-1:0] v);
    return {{(OPA_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  function automatic logic signed [OPB_W-1:0] ext_trig(input logic signed [31:0] v);
    return {{(OPB_W-32){v[31]}}, v};
  endfunction

endpackage

// File: rtl/core/nevpe_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// A 34x34 signed multiplier fed one chunk of operand A per cycle, with a
// registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module nevpe_mac import nevpe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nevpe_ctrl_t              ctrl_i,
  input  logic signed [OPA_W-1:0]  opa_i,
  input  logic signed [OPB_W-1:0]  opb_i,
  input  logic signed [ACC_W-1:0]  preload_i,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [OPA_W-1:0]  a_hi_full;
  logic signed [OPB_W-1:0]  chunk;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     pv_q, ph_q;
  logic signed [ACC_W-1:0]  addend, acc_q;

  // Low chunk is unsigned, high chunk carries the sign.
  assign a_hi_full = opa_i >>> LO_CHUNK;
  assign chunk     = ctrl_i.hi ? a_hi_full[OPB_W-1:0] : {1'b0, opa_i[LO_CHUNK-1:0]};
  assign prod_d    = chunk * opb_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ph_q <= 1'b0;
    end else begin
      pv_q <= ctrl_i.issue;
      ph_q <= ctrl_i.hi;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // High-chunk products are weighted by two to the chunk width.
  assign addend = ph_q ? ({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} << LO_CHUNK)
                       : {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.preload) begin
      acc_q <= preload_i;
    end else if (pv_q) begin
      acc_q <= acc_q + addend;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/nevpe_seq.sv
// ----------------------------------------------------------------------------
// Estimator sequencer
// Steps through the jobs of one transaction, one job after another.
// ----------------------------------------------------------------------------
module nevpe_seq import nevpe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  nevpe_status_t status_i,
  input  logic          out_free_i,
  output nevpe_ctrl_t   ctrl_o,
  output logic          ready_o,
  output logic          load_o
);

  nevpe_state_e      state_q, state_d;
  nevpe_job_e        job_q, job_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic [SUB_W-1:0]  sub_q, sub_d;
  logic              run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_VT;
      axis_q  <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      axis_q  <= axis_d;
      sub_q   <= sub_d;
    end
  end

  // Per-cycle control: preload, four chunk issues, drain, writeback.
  assign run            = (state_q == ST_RUN);
  assign ctrl_o.job     = job_q;
  assign ctrl_o.axis    = axis_q;
  assign ctrl_o.preload = run && (sub_q == 3'd0);
  assign ctrl_o.issue   = run && (sub_q >= 3'd1) && (sub_q <= 3'd4);
  assign ctrl_o.hi      = (sub_q == 3'd2) || (sub_q == 3'd4);
  assign ctrl_o.term    = (sub_q >= 3'd3);
  assign ctrl_o.wb      = run && (sub_q == SUB_WB);
  assign ready_o        = (state_q == ST_IDLE);
  assign load_o         = (state_q == ST_HOLD) && out_free_i;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    axis_d  = axis_q;
    sub_d   = sub_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          job_d   = JOB_VT;
          axis_d  = '0;
          sub_d   = '0;
        end
      end
      ST_RUN: begin
        sub_d = sub_q + 3'd1;
        if (sub_q == SUB_WB) begin
          sub_d = '0;
          case (job_q)
            JOB_VT, JOB_VB: begin
              if (job_q == JOB_VT && status_i.vel_ok) begin
                job_d = JOB_VB;
              end else if (axis_q == LAST_AXIS) begin
                job_d  = JOB_ET;
                axis_d = '0;
              end else begin
                job_d  = JOB_VT;
                axis_d = axis_q + 2'd1;
              end
            end
            JOB_ET: job_d = JOB_EX;
            JOB_EX: job_d = JOB_EY;
            JOB_EY: job_d = JOB_EZ;
            JOB_EZ: begin
              job_d  = JOB_PT;
              axis_d = '0;
            end
            JOB_PT, JOB_PB: begin
              if (job_q == JOB_PT && status_i.pos_ok) begin
                job_d = JOB_PB;
              end else if (axis_q == LAST_AXIS) begin
                state_d = ST_HOLD;
              end else begin
                job_d  = JOB_PT;
                axis_d = axis_q + 2'd1;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HOLD: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/ned_ecef_velocity_position_estimator.sv
// ----------------------------------------------------------------------------
// NED/ECEF velocity and position estimator
// Each transaction runs ten to sixteen jobs in turn on the one shared
// 34x34 multiply-accumulate unit before its result is registered. The
// blend jobs run only when the matching measurement is present.
// The input is not ready while a transaction is in work; a finished result
// waits in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
`include "ned_ecef_velocity_position_estimator_macros.svh"

module ned_ecef_velocity_position_estimator import nevpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nevpe_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output nevpe_out_t out_data_o
);

  // Configuration registers.
  logic [31:0] step_q;
  logic [30:0] vblend_q, pblend_q;
  logic [31:0] cos_lat_q, sin_lat_q, cos_lon_q, sin_lon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= STEP_RESET;
      vblend_q  <= BLEND_ONE;
      pblend_q  <= BLEND_ONE;
      cos_lat_q <= TRIG_ONE;
      sin_lat_q <= '0;
      cos_lon_q <= TRIG_ONE;
      sin_lon_q <= '0;
    end else if (cfg_we_i) begin
      case (nevpe_cfg_e'(cfg_addr_i))
        CFG_STEP_PERIOD: step_q    <= cfg_wdata_i;
        CFG_VEL_BLEND:   vblend_q  <= cfg_wdata_i[30:0];
        CFG_POS_BLEND:   pblend_q  <= cfg_wdata_i[30:0];
        CFG_COS_LAT:     cos_lat_q <= cfg_wdata_i;
        CFG_SIN_LAT:     sin_lat_q <= cfg_wdata_i;
        CFG_COS_LON:     cos_lon_q <= cfg_wdata_i;
        CFG_SIN_LON:     sin_lon_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Weights above one count as one.
  logic [30:0] wv, wp, wv_c, wp_c;
  assign wv   = (vblend_q > BLEND_ONE) ? BLEND_ONE : vblend_q;
  assign wp   = (pblend_q > BLEND_ONE) ? BLEND_ONE : pblend_q;
  assign wv_c = BLEND_ONE - wv;
  assign wp_c = BLEND_ONE - wp;

  // Sequencer.
  nevpe_ctrl_t   seq_ctrl;
  nevpe_status_t status;
  logic          accept, out_load, out_free;
  nevpe_in_t     in_q;
  nevpe_out_t    out_q;
  logic          out_valid_q;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  nevpe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .status_i   (status),
    .out_free_i (out_free),
    .ctrl_o     (seq_ctrl),
    .ready_o    (in_ready_o),
    .load_o     (out_load)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // Captured transaction as per-axis arrays.
  logic signed [VEL_W-1:0] acc_in [AXES];
  logic signed [VEL_W-1:0] vm     [AXES];
  logic signed [POS_W-1:0] pm     [AXES];

  assign acc_in[0] = in_q.accel_north;
  assign acc_in[1] = in_q.accel_east;
  assign acc_in[2] = in_q.accel_down;
  assign vm[0]     = in_q.vel_meas_north;
  assign vm[1]     = in_q.vel_meas_east;
  assign vm[2]     = in_q.vel_meas_down;
  assign pm[0]     = in_q.pos_meas_x;
  assign pm[1]     = in_q.pos_meas_y;
  assign pm[2]     = in_q.pos_meas_z;

  // A measurement with any zero component is absent.
  assign status.vel_ok = (vm[0] != '0) && (vm[1] != '0) && (vm[2] != '0);
  assign status.pos_ok = (pm[0] != '0) && (pm[1] != '0) && (pm[2] != '0);

  // Estimator state.
  logic signed [VEL_W-1:0] vel_est_q  [AXES];
  logic signed [POS_W-1:0] pos_est_q  [AXES];
  logic signed [VEL_W-1:0] prev_acc_q [AXES];
  logic signed [VEL_W-1:0] prev_ev_q  [AXES];
  logic signed [VEL_W-1:0] ev_q       [AXES];
  logic signed [T_W-1:0]   t_q;

  // Operand selection for the current job and product term.
  logic signed [OPA_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [ACC_W-1:0] preload;
  logic signed [OPA_W-1:0] n_a, e_a, d_a, t_a;
  logic [AXIS_W-1:0]       ax;

  assign ax  = seq_ctrl.axis;
  assign n_a = ext_vel(vel_est_q[0]);
  assign e_a = ext_vel(vel_est_q[1]);
  assign d_a = ext_vel(vel_est_q[2]);
  assign t_a = {{(OPA_W-T_W){t_q[T_W-1]}}, t_q};

  always_comb begin
    opa     = '0;
    opb     = '0;
    preload = '0;
    case (seq_ctrl.job)
      JOB_VT: begin
        preload = {{(ACC_W-VEL_W){vel_est_q[ax][VEL_W-1]}}, vel_est_q[ax]} << SHIFT_TRAPZ;
        if (!seq_ctrl.term) begin
          opa = ext_vel(prev_acc_q[ax]) + ext_vel(acc_in[ax]);
          opb = {2'b00, step_q};
        end
      end
      JOB_VB: begin
        opa = seq_ctrl.term ? ext_vel(vm[ax]) : ext_vel(vel_est_q[ax]);
        opb = seq_ctrl.term ? {3'b000, wv_c} : {3'b000, wv};
      end
      JOB_ET: begin
        opa = seq_ctrl.term ? -n_a : -d_a;
        opb = seq_ctrl.term ? ext_trig(sin_lat_q) : ext_trig(cos_lat_q);
      end
      JOB_EX: begin
        opa = seq_ctrl.term ? -e_a : t_a;
        opb = seq_ctrl.term ? ext_trig(sin_lon_q) : ext_trig(cos_lon_q);
      end
      JOB_EY: begin
        opa = seq_ctrl.term ? e_a : t_a;
        opb = seq_ctrl.term ? ext_trig(cos_lon_q) : ext_trig(sin_lon_q);
      end
      JOB_EZ: begin
        opa = seq_ctrl.term ? -d_a : n_a;
        opb = seq_ctrl.term ? ext_trig(sin_lat_q) : ext_trig(cos_lat_q);
      end
      JOB_PT: begin
        preload = {{(ACC_W-POS_W){pos_est_q[ax][POS_W-1]}}, pos_est_q[ax]} << SHIFT_TRAPZ;
        if (!seq_ctrl.term) begin
          opa = ext_vel(prev_ev_q[ax]) + ext_vel(ev_q[ax]);
          opb = {2'b00, step_q};
        end
      end
      JOB_PB: begin
        opa = seq_ctrl.term ? ext_pos(pm[ax]) : ext_pos(pos_est_q[ax]);
        opb = seq_ctrl.term ? {3'b000, wp_c} : {3'b000, wp};
      end
      default: ;
    endcase
  end

  logic signed [ACC_W-1:0] acc;

  nevpe_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (seq_ctrl),
    .opa_i     (opa),
    .opb_i     (opb),
    .preload_i (preload),
    .acc_o     (acc)
  );

  // Rounding to nearest, ties up, then saturation to the target width.
  logic signed [ACC_W-1:0] rnd25, rnd30;
  logic signed [VEL_W-1:0] v25, v30;
  logic signed [POS_W-1:0] p25, p30;

  assign rnd25 = (acc + (ACC_W'(1) << (SHIFT_TRAPZ - 1))) >>> SHIFT_TRAPZ;
  assign rnd30 = (acc + (ACC_W'(1) << (SHIFT_TRIG - 1))) >>> SHIFT_TRIG;

  function automatic logic signed [VEL_W-1:0] sat_v(input logic signed [ACC_W-1:0] x);
    logic fits;
    fits = (&x[ACC_W-1:VEL_W-1]) || !(|x[ACC_W-1:VEL_W-1]);
    if (fits) return x[VEL_W-1:0];
    return x[ACC_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

  function automatic logic signed [POS_W-1:0] sat_p(input logic signed [ACC_W-1:0] x);
    logic fits;
    fits = (&x[ACC_W-1:POS_W-1]) || !(|x[ACC_W-1:POS_W-1]);
    if (fits) return x[POS_W-1:0];
    return x[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  assign v25 = sat_v(rnd25);
  assign v30 = sat_v(rnd30);
  assign p25 = sat_p(rnd25);
  assign p30 = sat_p(rnd30);

  // Writeback of each finished job into the estimator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        vel_est_q[i]  <= '0;
        pos_est_q[i]  <= '0;
        prev_acc_q[i] <= '0;
        prev_ev_q[i]  <= '0;
      end
    end else if (seq_ctrl.wb) begin
      case (seq_ctrl.job)
        JOB_VT: begin
          vel_est_q[ax]  <= v25;
          prev_acc_q[ax] <= acc_in[ax];
        end
        JOB_VB: vel_est_q[ax] <= v30;
        JOB_PT: begin
          pos_est_q[ax] <= p25;
          prev_ev_q[ax] <= ev_q[ax];
        end
        JOB_PB: pos_est_q[ax] <= p30;
        default: ;
      endcase
    end
  end

  // Rotation intermediates live only within one transaction.
  always_ff @(posedge clk_i) begin
    if (seq_ctrl.wb) begin
      case (seq_ctrl.job)
        JOB_ET: t_q      <= rnd30[T_W-1:0];
        JOB_EX: ev_q[0]  <= v30;
        JOB_EY: ev_q[1]  <= v30;
        JOB_EZ: ev_q[2]  <= v30;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.vel_est_north <= vel_est_q[0];
      out_q.vel_est_east  <= vel_est_q[1];
      out_q.vel_est_down  <= vel_est_q[2];
      out_q.pos_est_x     <= pos_est_q[0];
      out_q.pos_est_y     <= pos_est_q[1];
      out_q.pos_est_z     <= pos_est_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks.
  `NEVPE_ASSERT_NXT(a_busy_after_accept, accept, !in_ready_o, "input ready right after accept")
  `NEVPE_ASSERT_IMP(a_no_issue_idle, seq_ctrl.issue, !in_ready_o, "multiplier used while idle")
  `NEVPE_ASSERT_NXT(a_load_sets_valid, out_load, out_valid_o, "result load did not set valid")

endmodule
